@@ rtl/core/gsbe_pkg.sv @@
package gsbe_pkg;

   // Number of static samples per batch is 2**SAMPLES_LOG2. The batch sum is
   // the average with SAMPLES_LOG2 fraction bits.
   localparam int SAMPLES_LOG2 = 5;
   localparam int BATCH_SIZE   = 1 << SAMPLES_LOG2;

   localparam int RATE_W = 16;
   localparam int THR_W  = 15;
   localparam int LIM_W  = 20;
   localparam int BIAS_W = 21;
   localparam int CORR_W = 22;
   localparam int SUM_W  = RATE_W + SAMPLES_LOG2;
   localparam int CNT_W  = SAMPLES_LOG2;

   // Working width for the limit compare and the corrected difference.
   localparam int WIDE_W = ((SUM_W > BIAS_W) ? SUM_W : BIAS_W) + 1;

   localparam int AXES = 3;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = LIM_W;
   localparam logic [CSR_IDX_W-1:0] CSR_STATIC_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_LIMIT       = 2'd1;

   localparam logic [THR_W-1:0] THR_RESET = 15'd82;
   localparam logic [LIM_W-1:0] LIM_RESET = 20'd1573;

   // Result buffer.
   localparam int RSP_DEPTH = 3;
   localparam int LVL_W     = 2;

   localparam int REQ_TDATA_W = ((AXES * RATE_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((AXES * (CORR_W + BIAS_W) + 7) / 8) * 8;
   localparam int RSP_TUSER_W = 3;

   typedef enum logic [1:0] {
      BATCH_NONE   = 2'd0,
      BATCH_ACCEPT = 2'd1,
      BATCH_REJECT = 2'd2
   } batch_type;

   typedef struct packed {
      logic [AXES-1:0][SUM_W-1:0]  sum;
      logic [CNT_W-1:0]            count;
      logic [AXES-1:0][BIAS_W-1:0] bias;
   } state_type;

   typedef struct packed {
      batch_type                   batch_result;
      logic                        is_static;
      logic [AXES-1:0][BIAS_W-1:0] bias;
      logic [AXES-1:0][CORR_W-1:0] corrected;
   } rsp_type;

endpackage

@@ rtl/core/gsbe_update.sv @@
module gsbe_update (
   input  logic [gsbe_pkg::AXES-1:0][gsbe_pkg::RATE_W-1:0] rate,
   input  logic [gsbe_pkg::THR_W-1:0]                      thr,
   input  logic [gsbe_pkg::LIM_W-1:0]                      lim,
   input  gsbe_pkg::state_type                             state,
   output gsbe_pkg::state_type                             state_in,
   output gsbe_pkg::rsp_type                               rsp
);

   localparam int W = gsbe_pkg::WIDE_W;
   localparam logic signed [W-1:0] CORR_MAX = W'((1 << (gsbe_pkg::CORR_W - 1)) - 1);
   localparam logic signed [W-1:0] CORR_MIN = -CORR_MAX - W'(1);

   always_comb begin
      logic signed [gsbe_pkg::RATE_W:0]   thr_s;
      logic signed [W-1:0]                lim_s;
      logic signed [gsbe_pkg::RATE_W:0]   rate_e;
      logic signed [gsbe_pkg::RATE_W-1:0] rate_s;
      logic signed [gsbe_pkg::SUM_W-1:0]  sum_s;
      logic signed [gsbe_pkg::SUM_W-1:0]  sum_new [gsbe_pkg::AXES];
      logic signed [gsbe_pkg::BIAS_W-1:0] bias_s;
      logic signed [W-1:0]                sum_w;
      logic signed [W-1:0]                diff;
      logic                               still;
      logic                               complete;
      logic                               in_limit;

      thr_s    = $signed({2'b00, thr});
      lim_s    = $signed(W'({1'b0, lim}));
      still    = 1'b1;
      in_limit = 1'b1;

      for (int i = 0; i < gsbe_pkg::AXES; i++) begin
         rate_s = $signed(rate[i]);
         rate_e = (gsbe_pkg::RATE_W + 1)'(rate_s);
         if (rate_e > thr_s || rate_e < -thr_s) begin
            still = 1'b0;
         end
         sum_s      = $signed(state.sum[i]);
         sum_new[i] = sum_s + gsbe_pkg::SUM_W'(rate_s);
         sum_w      = W'(sum_new[i]);
         if (sum_w > lim_s || sum_w < -lim_s) begin
            in_limit = 1'b0;
         end
      end

      // The last static sample of a batch closes it.
      complete = still && (state.count == gsbe_pkg::CNT_W'(gsbe_pkg::BATCH_SIZE - 1));

      state_in = state;
      if (still) begin
         if (complete) begin
            state_in.count = '0;
            for (int i = 0; i < gsbe_pkg::AXES; i++) begin
               state_in.sum[i] = '0;
               if (in_limit) begin
                  state_in.bias[i] = gsbe_pkg::BIAS_W'(W'(sum_new[i]));
               end
            end
         end else begin
            state_in.count = state.count + gsbe_pkg::CNT_W'(1);
            for (int i = 0; i < gsbe_pkg::AXES; i++) begin
               state_in.sum[i] = sum_new[i];
            end
         end
      end

      // Correction uses the bias as updated by this same sample.
      for (int i = 0; i < gsbe_pkg::AXES; i++) begin
         rate_s = $signed(rate[i]);
         bias_s = $signed(state_in.bias[i]);
         diff   = (W'(rate_s) <<< gsbe_pkg::SAMPLES_LOG2) - W'(bias_s);
         if (diff > CORR_MAX) begin
            diff = CORR_MAX;
         end else if (diff < CORR_MIN) begin
            diff = CORR_MIN;
         end
         rsp.corrected[i] = gsbe_pkg::CORR_W'(diff);
         rsp.bias[i]      = state_in.bias[i];
      end

      rsp.is_static = still;
      if (!complete) begin
         rsp.batch_result = gsbe_pkg::BATCH_NONE;
      end else if (in_limit) begin
         rsp.batch_result = gsbe_pkg::BATCH_ACCEPT;
      end else begin
         rsp.batch_result = gsbe_pkg::BATCH_REJECT;
      end
   end

endmodule

@@ rtl/core/gsbe_rsp_fifo.sv @@
module gsbe_rsp_fifo (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  gsbe_pkg::rsp_type            wr_data,
   output logic                         rd_valid,
   input  logic                         rd_ready,
   output gsbe_pkg::rsp_type            rd_data,
   output logic [gsbe_pkg::LVL_W-1:0]   level
);

   localparam logic [gsbe_pkg::LVL_W-1:0] LAST = gsbe_pkg::LVL_W'(gsbe_pkg::RSP_DEPTH - 1);

   gsbe_pkg::rsp_type               entry_ff [gsbe_pkg::RSP_DEPTH];
   logic [gsbe_pkg::LVL_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [gsbe_pkg::LVL_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [gsbe_pkg::LVL_W-1:0]      level_ff, level_in;
   logic                            pop;

   assign rd_valid = (level_ff != '0);
   assign rd_data  = entry_ff[rd_ptr_ff];
   assign level    = level_ff;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + gsbe_pkg::LVL_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + gsbe_pkg::LVL_W'(1);
      end
      if (wr_en && !pop) begin
         level_in = level_ff + gsbe_pkg::LVL_W'(1);
      end else if (pop && !wr_en) begin
         level_in = level_ff - gsbe_pkg::LVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ rtl/core/gyro_static_bias_estimator_core.sv @@
// Gyro static bias estimator.
//
// Requests arrive on the req_ stream, one raw three-axis gyro sample per
// request. Each request produces exactly one response on the rsp_ stream: the
// sample minus the current bias, the bias itself, and status flags. A sample
// is static when every axis lies within the static threshold; every
// 2**SAMPLES_LOG2 static samples the per-axis sums are checked against the
// bias limit and, if all fit, replace the bias.
// The csr_ channel writes the static threshold (index 0) and the bias limit
// (index 1); it is always ready and should be used only while the block is idle.
// rsp_tvalid rises once an accepted request has passed the input register and
// been written into the response buffer. Throughput is one request per cycle
// while the buffer has room: the whole update is one registered pass from the
// input register to a three-entry response buffer.
// When the receiver stalls, the buffer keeps absorbing requests; req_tready
// drops only once the buffer plus the input register hold three requests.
// Synchronous reset clears the sums, the count and the bias, restores the
// register defaults (threshold 82, limit 1573) and empties the pipeline.
module gyro_static_bias_estimator_core (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata, from bit 0: rate_x[15:0], rate_y[15:0], rate_z[15:0]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [gsbe_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // rsp_tdata, from bit 0: corrected_x[21:0], corrected_y[21:0],
   // corrected_z[21:0], bias_x[20:0], bias_y[20:0], bias_z[20:0], zero fill
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [gsbe_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // rsp_tuser, from bit 0: is_static, batch_result[1:0]
   output logic [gsbe_pkg::RSP_TUSER_W-1:0]  rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gsbe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gsbe_pkg::CSR_DATA_W-1:0]   csr_data
);

   logic [gsbe_pkg::THR_W-1:0]                     thr_ff, thr_in;
   logic [gsbe_pkg::LIM_W-1:0]                     lim_ff, lim_in;
   logic                                           s1_valid_ff;
   logic [gsbe_pkg::AXES-1:0][gsbe_pkg::RATE_W-1:0] s1_rate_ff;
   gsbe_pkg::state_type                            state_ff, state_in;
   gsbe_pkg::rsp_type                              upd_rsp;
   gsbe_pkg::rsp_type                              out_rsp;
   logic [gsbe_pkg::LVL_W-1:0]                     level;
   logic                                           req_accept;

   assign csr_ready  = 1'b1;
   assign req_accept = req_tvalid && req_tready;

   // Credit check: the input register and the buffer together never hold more
   // requests than the buffer can take.
   assign req_tready = ({1'b0, level} + {2'b00, s1_valid_ff})
                       < (gsbe_pkg::LVL_W + 1)'(gsbe_pkg::RSP_DEPTH);

   always_comb begin
      thr_in = thr_ff;
      lim_in = lim_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == gsbe_pkg::CSR_STATIC_THRESHOLD) begin
            thr_in = csr_data[gsbe_pkg::THR_W-1:0];
         end else if (csr_index == gsbe_pkg::CSR_BIAS_LIMIT) begin
            lim_in = csr_data[gsbe_pkg::LIM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff      <= gsbe_pkg::THR_RESET;
         lim_ff      <= gsbe_pkg::LIM_RESET;
         s1_valid_ff <= 1'b0;
         state_ff    <= '0;
      end else begin
         thr_ff      <= thr_in;
         lim_ff      <= lim_in;
         s1_valid_ff <= req_accept;
         if (s1_valid_ff) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_rate_ff <= req_tdata[gsbe_pkg::AXES*gsbe_pkg::RATE_W-1:0];
      end
   end

   gsbe_update u_update (
      .rate     (s1_rate_ff),
      .thr      (thr_ff),
      .lim      (lim_ff),
      .state    (state_ff),
      .state_in (state_in),
      .rsp      (upd_rsp)
   );

   gsbe_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (s1_valid_ff),
      .wr_data  (upd_rsp),
      .rd_valid (rsp_tvalid),
      .rd_ready (rsp_tready),
      .rd_data  (out_rsp),
      .level    (level)
   );

   assign rsp_tdata = gsbe_pkg::RSP_TDATA_W'({out_rsp.bias, out_rsp.corrected});
   assign rsp_tuser = {out_rsp.batch_result, out_rsp.is_static};

   // An accepted request reaches the update stage on the next edge.
   a_req_to_stage: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted request did not reach the update stage");

   // The update stage never writes into a full response buffer.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (level != gsbe_pkg::LVL_W'(gsbe_pkg::RSP_DEPTH)
                       || (rsp_tvalid && rsp_tready)))
      else $error("response buffer overflow");

   // A closed batch restarts the static count.
   a_batch_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && upd_rsp.batch_result != gsbe_pkg::BATCH_NONE)
      |=> (state_ff.count == '0))
      else $error("static count not cleared after batch");

   // Only a static sample can close a batch.
   a_batch_static: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_rsp.batch_result != gsbe_pkg::BATCH_NONE)
      |-> out_rsp.is_static)
      else $error("batch result on a non-static sample");

endmodule

@@ verif/testbench.sv @@
module testbench;

   // The two register indexes beyond the defined pair. Writes to them must be
   // ignored by the block.
   localparam logic [gsbe_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [gsbe_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   // Saturation bounds of the corrected rate.
   localparam longint CORR_HI = (64'sd1 <<< (gsbe_pkg::CORR_W - 1)) - 1;
   localparam longint CORR_LO = -(64'sd1 <<< (gsbe_pkg::CORR_W - 1));

   localparam int          STALL_LEN    = 400;
   localparam int          DRAIN_CYCLES = 20;
   localparam int unsigned CYCLE_LIMIT  = 400000;

   // One raw gyro request as it sits on req_tdata, x in the lowest bits.
   typedef struct packed {
      logic signed [gsbe_pkg::RATE_W-1:0] z;
      logic signed [gsbe_pkg::RATE_W-1:0] y;
      logic signed [gsbe_pkg::RATE_W-1:0] x;
   } gyro_sample_type;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [gsbe_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [gsbe_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [gsbe_pkg::RSP_TUSER_W-1:0] rsp_tuser;
   logic                             csr_valid  = 1'b0;
   logic                             csr_ready;
   logic [gsbe_pkg::CSR_IDX_W-1:0]   csr_index  = '0;
   logic [gsbe_pkg::CSR_DATA_W-1:0]  csr_data   = '0;

   gyro_static_bias_estimator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // Samples waiting to be offered, and the corrected results still owed by
   // the block, oldest first.
   gyro_sample_type   sample_queue[$];
   gsbe_pkg::rsp_type expected_corrections[$];

   // Our own copy of the estimator: registers, accumulators and bias.
   logic [gsbe_pkg::THR_W-1:0] static_thr;
   logic [gsbe_pkg::LIM_W-1:0] bias_lim;
   longint                     acc_sum [gsbe_pkg::AXES];
   int                         acc_count;
   longint                     cur_bias [gsbe_pkg::AXES];

   // Traffic shaping, set by the sequencer between phases.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int stall_request  = 0;
   int stall_served   = 0;
   int stall_left     = 0;

   // Handshake bookkeeping. The counters are updated with nonblocking writes
   // so the sequencer sees settled values at the rising edge.
   logic        req_taken         = 1'b0;
   int unsigned requests_accepted = 0;
   int unsigned results_checked   = 0;
   int unsigned failures          = 0;
   int unsigned cycle_count       = 0;

   string axis_tag [gsbe_pkg::AXES] = '{"x", "y", "z"};

   // Works out the result of one sample and advances the estimator state.
   // A sample is static only when all three axes lie within the threshold;
   // every BATCH_SIZE static samples the sums, which already are the average
   // with SAMPLES_LOG2 fraction bits, either replace the bias or are dropped.
   function automatic gsbe_pkg::rsp_type correct_sample(gyro_sample_type s);
      gsbe_pkg::rsp_type r;
      longint  rate [gsbe_pkg::AXES];
      longint  thr;
      longint  lim;
      longint  diff;
      bit      still;
      bit      fits;
      int      a;
      rate[0] = $signed(s.x);
      rate[1] = $signed(s.y);
      rate[2] = $signed(s.z);
      thr = static_thr;
      lim = bias_lim;
      still = 1'b1;
      for (a = 0; a < gsbe_pkg::AXES; a++) begin
         if (rate[a] < -thr || rate[a] > thr) still = 1'b0;
      end
      r.batch_result = gsbe_pkg::BATCH_NONE;
      if (still) begin
         for (a = 0; a < gsbe_pkg::AXES; a++) acc_sum[a] += rate[a];
         acc_count++;
         if (acc_count == gsbe_pkg::BATCH_SIZE) begin
            fits = 1'b1;
            for (a = 0; a < gsbe_pkg::AXES; a++) begin
               if (acc_sum[a] < -lim || acc_sum[a] > lim) fits = 1'b0;
            end
            if (fits) begin
               for (a = 0; a < gsbe_pkg::AXES; a++) cur_bias[a] = acc_sum[a];
               r.batch_result = gsbe_pkg::BATCH_ACCEPT;
            end else begin
               r.batch_result = gsbe_pkg::BATCH_REJECT;
            end
            for (a = 0; a < gsbe_pkg::AXES; a++) acc_sum[a] = 0;
            acc_count = 0;
         end
      end
      // The correction uses the bias as this very sample may have left it.
      for (a = 0; a < gsbe_pkg::AXES; a++) begin
         diff = rate[a] * gsbe_pkg::BATCH_SIZE - cur_bias[a];
         if (diff > CORR_HI) diff = CORR_HI;
         if (diff < CORR_LO) diff = CORR_LO;
         r.corrected[a] = diff[gsbe_pkg::CORR_W-1:0];
         r.bias[a] = cur_bias[a][gsbe_pkg::BIAS_W-1:0];
      end
      r.is_static = still;
      return r;
   endfunction

   task automatic check_field(string name, logic signed [63:0] want,
                              logic signed [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   // Monitor and predictor. Everything here is sampled at the rising edge,
   // before the block's own registers move.
   always @(posedge clock) begin
      gsbe_pkg::rsp_type want;
      gsbe_pkg::rsp_type got;
      int      a;
      if (reset) begin
         static_thr = gsbe_pkg::THR_RESET;
         bias_lim   = gsbe_pkg::LIM_RESET;
         for (a = 0; a < gsbe_pkg::AXES; a++) begin
            acc_sum[a]  = 0;
            cur_bias[a] = 0;
         end
         acc_count = 0;
         req_taken <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               gsbe_pkg::CSR_STATIC_THRESHOLD:
                  static_thr = csr_data[gsbe_pkg::THR_W-1:0];
               gsbe_pkg::CSR_BIAS_LIMIT:
                  bias_lim = csr_data[gsbe_pkg::LIM_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = gsbe_pkg::rsp_type'({rsp_tuser,
               rsp_tdata[gsbe_pkg::AXES*(gsbe_pkg::CORR_W+gsbe_pkg::BIAS_W)-1:0]});
            if (expected_corrections.size() == 0) begin
               $error("response with no request outstanding: tdata %h tuser %h",
                      rsp_tdata, rsp_tuser);
               failures++;
            end else begin
               want = expected_corrections.pop_front();
               for (a = 0; a < gsbe_pkg::AXES; a++) begin
                  check_field({"corrected_", axis_tag[a]}, $signed(want.corrected[a]),
                              $signed(got.corrected[a]));
               end
               for (a = 0; a < gsbe_pkg::AXES; a++) begin
                  check_field({"bias_", axis_tag[a]}, $signed(want.bias[a]),
                              $signed(got.bias[a]));
               end
               check_field("is_static", want.is_static, got.is_static);
               check_field("batch_result", want.batch_result, got.batch_result);
               results_checked <= results_checked + 1;
            end
         end
         // A response can never belong to a request taken at the same edge,
         // so the new expectation goes in after the check above.
         if (req_tvalid && req_tready) begin
            expected_corrections.push_back(correct_sample(gyro_sample_type'(req_tdata)));
            requests_accepted <= requests_accepted + 1;
         end
         req_taken <= req_tvalid && req_tready;
      end
   end

   // Request driver. A new sample is offered only once the previous one has
   // been taken, so tvalid never falls while a request is pending.
   always @(negedge clock) begin
      if (!reset && (req_taken || !req_tvalid)) begin
         if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= sample_queue.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response receiver. A long hold-off, when requested, is counted here so
   // the sender keeps offering requests while the block backs up.
   always @(negedge clock) begin
      if (stall_request != stall_served) begin
         stall_served = stall_request;
         stall_left   = STALL_LEN;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !reset && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic push_sample(int x, int y, int z);
      gyro_sample_type s;
      s.x = 16'(x);
      s.y = 16'(y);
      s.z = 16'(z);
      sample_queue.push_back(s);
   endtask

   // Full-range value for samples that should break a static run. The two
   // extremes are forced now and then since a uniform draw rarely hits them.
   function automatic int wild_rate();
      case ($urandom_range(7))
         0:       return -32768;
         1:       return 32767;
         default: return int'($signed(16'($urandom)));
      endcase
   endfunction

   // Mostly batches of static samples scattered around a per-batch center,
   // which decides whether the batch lands inside the bias limit. Among them
   // sit full-range noise samples and near misses one step past the threshold.
   task automatic queue_samples(int thr, int count);
      int center [gsbe_pkg::AXES];
      int v [gsbe_pkg::AXES];
      int spread;
      int still_n;
      int kind;
      int n;
      int a;
      spread  = thr / 8 + 1;
      still_n = 0;
      for (n = 0; n < count; n++) begin
         if (still_n % gsbe_pkg::BATCH_SIZE == 0) begin
            for (a = 0; a < gsbe_pkg::AXES; a++) begin
               center[a] = int'($urandom_range(2 * thr)) - thr;
            end
         end
         kind = $urandom_range(99);
         if (kind < 10) begin
            for (a = 0; a < gsbe_pkg::AXES; a++) v[a] = wild_rate();
         end else begin
            for (a = 0; a < gsbe_pkg::AXES; a++) begin
               v[a] = center[a] + int'($urandom_range(2 * spread)) - spread;
               if ($urandom_range(15) == 0) v[a] = $urandom_range(1) ? thr : -thr;
               if (v[a] > thr) v[a] = thr;
               if (v[a] < -thr) v[a] = -thr;
            end
            if (kind < 14) begin
               a = $urandom_range(gsbe_pkg::AXES - 1);
               if (thr == 32767) v[a] = -32768;
               else v[a] = $urandom_range(1) ? thr + 1 : -thr - 1;
            end else begin
               still_n++;
            end
         end
         push_sample(v[0], v[1], v[2]);
      end
   endtask

   task automatic write_csr(logic [gsbe_pkg::CSR_IDX_W-1:0] idx,
                            logic [gsbe_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Returns at a rising edge once every queued sample has been taken and
   // every response it caused has been checked.
   task automatic wait_drained();
      do @(posedge clock);
      while (sample_queue.size() != 0 || req_tvalid || results_checked != requests_accepted);
   endtask

   // Each phase starts from an idle block: the sender pauses until all
   // outstanding responses are in, then both registers are rewritten.
   task automatic run_phase(logic [gsbe_pkg::CSR_DATA_W-1:0] thr_word,
                            logic [gsbe_pkg::CSR_DATA_W-1:0] lim,
                            int send_pct, int recv_pct, int count, bit long_hold);
      wait_drained();
      write_csr(gsbe_pkg::CSR_STATIC_THRESHOLD, thr_word);
      write_csr(gsbe_pkg::CSR_BIAS_LIMIT, lim);
      @(posedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      if (long_hold) stall_request++;
      queue_samples(int'(thr_word[gsbe_pkg::THR_W-1:0]), count);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests under the reset defaults (threshold 82): zero, the
      // threshold bounds and one step past them on each axis, the field
      // extremes, and the most negative rate, which can never be static.
      push_sample(0, 0, 0);
      push_sample(82, 82, 82);
      push_sample(-82, -82, -82);
      push_sample(83, 0, 0);
      push_sample(0, -83, 0);
      push_sample(0, 0, 83);
      push_sample(82, -82, 0);
      push_sample(-1, 1, -1);
      push_sample(32767, 32767, 32767);
      push_sample(-32768, -32768, -32768);
      push_sample(-32768, 0, 0);
      push_sample(0, 32767, 0);
      push_sample(21845, -21846, 10922);
      push_sample(-21846, 21845, -10923);
      push_sample(5, -7, 3);

      // Writes to the spare indexes must leave both registers untouched.
      wait_drained();
      write_csr(CSR_SPARE_A, 20'hFFFFF);
      write_csr(CSR_SPARE_B, 20'h00000);

      // The threshold word carries junk above bit 14, which must be dropped,
      // leaving the default of 82.
      run_phase(20'hA8052, 20'd1573, 0, 0, 500, 1'b0);
      run_phase(20'd32767, 20'hFFFFF, 76, 0, 250, 1'b0);
      run_phase(20'd0, 20'd0, 0, 76, 250, 1'b0);
      run_phase(20'd500, 20'd4000, 27, 27, 300, 1'b0);
      // The receiver holds off for a long stretch at the start of this phase
      // while the sender keeps going, so the block fills and stalls req_.
      run_phase(20'd40, 20'd600, 0, 0, 300, 1'b1);
      run_phase(20'($urandom_range(32767)), 20'($urandom), 27, 27, 300, 1'b0);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (failures == 0 && expected_corrections.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ gyro_static_bias_estimator_core.f @@
rtl/core/gsbe_pkg.sv
rtl/core/gsbe_update.sv
rtl/core/gsbe_rsp_fifo.sv
rtl/core/gyro_static_bias_estimator_core.sv
verif/testbench.sv
